### hdl/rational_arith_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// Clocked on aclk, quiet while aresetn is low.
`define RAU_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Same, with a generic message.
`define RAU_ASSERT(lbl, prop) \
    `RAU_ASSERT_MSG(lbl, prop, "rational_arith_unit port check failed")

`endif

### hdl/rau_pkg.sv
package rau_pkg;

    localparam int CMD_W = 3;
    localparam int EXP_W = 7;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ABS = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POW = 3'd5;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
    localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

    // status of an iterative unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

### hdl/rational_arith_unit.sv
// Channel  Dir  tdata (low bit up)                        tuser
// s_       in   a_num, a_den, b_num, b_den, exponent      cmd
// m_       out  res_num, res_den                          status
//
// One transaction at a time; s_tready is high only while idle.
// An error or unused command goes from the check straight to the output. Otherwise the check
// is followed by three products on the shared multiplier, a binary gcd, two divisions by
// the gcd, and for power the multiplies on the same unit.
// Reset (aresetn low, synchronous) clears the sequencer and the output valid.
// A result waits in the output register while the next transaction is taken in.
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = 16,
    parameter int EXP_MAX       = 32
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // a_num, a_den, b_num, b_den, exponent
    input  logic [((4*OPERAND_WIDTH+rau_pkg::EXP_W+7)/8)*8-1:0] s_tdata,
    // cmd
    input  logic [rau_pkg::CMD_W-1:0]                       s_tuser,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // res_num, res_den
    output logic [((2*OPERAND_WIDTH-1+7)/8)*8-1:0]          m_tdata,
    // status
    output logic [rau_pkg::ST_W-1:0]                        m_tuser
);

    localparam int W     = OPERAND_WIDTH;
    localparam int NW    = 2 * W + 1;
    localparam int EXW   = rau_pkg::EXP_W;
    localparam int OUT_W = ((2*W - 1 + 7) / 8) * 8;
    localparam logic [W-1:0]  POS_MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  NEG_MAX_W = {1'b1, {(W-1){1'b0}}};
    localparam logic [NW-1:0] POS_MAX_N = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [NW-1:0] NEG_MAX_N = POS_MAX_N + NW'(1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_GCD   = 8'b0000_1000,
        S_DIVN  = 8'b0001_0000,
        S_DIVD  = 8'b0010_0000,
        S_POW   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [rau_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [W-1:0]    an_reg, an_next, ad_reg, ad_next, bn_reg, bn_next, bd_reg, bd_next;
    logic [EXW-1:0]  ex_reg, ex_next, i_reg, i_next;
    logic [1:0]      k_reg, k_next;
    logic [2*W-1:0]  p0_reg, p0_next, p1_reg, p1_next;
    logic [NW-1:0]   n_reg, n_next, d_reg, d_next, g_reg, g_next;
    logic            neg_reg, neg_next, go_reg, go_next;
    logic [rau_pkg::ST_W-1:0] st_reg, st_next, rst_reg, rst_next;
    logic [W-1:0]    bp_reg, bp_next, bq_reg, bq_next, acc_reg, acc_next;
    logic            ph_reg, ph_next, half_reg, half_next, mv_reg, mv_next;
    logic [W-1:0]    rnum_reg, rnum_next;
    logic [W-2:0]    rden_reg, rden_next;

    logic [W-1:0]    an_mag, ad_mag, bn_mag, bd_mag, mx, my, lim, p_sw, q_sw;
    logic [EXW-1:0]  ex_mag;
    logic            is_addsub, is_unary, s0, s1, sden;
    logic [2*W-1:0]  prod;
    logic [NW:0]     t0, t1, sum;
    logic [NW-1:0]   sum_mag, div_a, gcd_g, quo, n_f, d_f;
    logic            neg_f;
    logic [rau_pkg::ST_W-1:0] st_f;
    rau_pkg::unit_sts_t gcd_sts, div_sts;

    assign an_mag = an_reg[W-1] ? (~an_reg + 1'b1) : an_reg;
    assign ad_mag = ad_reg[W-1] ? (~ad_reg + 1'b1) : ad_reg;
    assign bn_mag = bn_reg[W-1] ? (~bn_reg + 1'b1) : bn_reg;
    assign bd_mag = bd_reg[W-1] ? (~bd_reg + 1'b1) : bd_reg;
    assign ex_mag = ex_reg[EXW-1] ? (~ex_reg + 1'b1) : ex_reg;

    assign is_addsub = (cmd_reg == rau_pkg::CMD_ADD) || (cmd_reg == rau_pkg::CMD_SUB);
    assign is_unary  = (cmd_reg == rau_pkg::CMD_ABS) || (cmd_reg == rau_pkg::CMD_POW);

    // term signs: first product, second product (add/sub), denominator
    assign s0   = is_unary ? an_reg[W-1]
                : an_reg[W-1] ^ ((cmd_reg == rau_pkg::CMD_MUL) ? bn_reg[W-1] : bd_reg[W-1]);
    assign s1   = bn_reg[W-1] ^ ad_reg[W-1] ^ (cmd_reg == rau_pkg::CMD_SUB);
    assign sden = is_unary ? ad_reg[W-1]
                : ad_reg[W-1] ^ ((cmd_reg == rau_pkg::CMD_DIV) ? bn_reg[W-1] : bd_reg[W-1]);

    // shared multiplier operand select
    always_comb begin
        mx = ad_mag;
        my = bd_mag;
        if (state_reg == S_POW) begin
            mx = acc_reg;
            my = ph_reg ? bq_reg : bp_reg;
        end else begin
            case (k_reg)
                2'd0: begin
                    mx = an_mag;
                    if (cmd_reg == rau_pkg::CMD_MUL) begin
                        my = bn_mag;
                    end else if (is_unary) begin
                        my = W'(1);
                    end else begin
                        my = bd_mag;
                    end
                end
                2'd1: begin
                    mx = is_addsub ? bn_mag : '0;
                    my = ad_mag;
                end
                default: begin
                    mx = ad_mag;
                    if (cmd_reg == rau_pkg::CMD_DIV) begin
                        my = bn_mag;
                    end else if (is_unary) begin
                        my = W'(1);
                    end else begin
                        my = bd_mag;
                    end
                end
            endcase
        end
    end

    rau_mul #(.WIDTH(W)) u_mul (
        .aclk (aclk),
        .x    (mx),
        .y    (my),
        .prod (prod)
    );

    rau_gcd #(.WIDTH(NW)) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg && (state_reg == S_GCD)),
        .x       (n_reg),
        .y       (d_reg),
        .sts     (gcd_sts),
        .g       (gcd_g)
    );

    assign div_a = (state_reg == S_DIVD) ? d_reg : n_reg;

    rau_div #(.WIDTH(NW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg && ((state_reg == S_DIVN) || (state_reg == S_DIVD))),
        .a       (div_a),
        .b       (g_reg),
        .sts     (div_sts),
        .q       (quo)
    );

    assign t0      = s0 ? -{2'b00, p0_reg} : {2'b00, p0_reg};
    assign t1      = s1 ? -{2'b00, p1_reg} : {2'b00, p1_reg};
    assign sum     = t0 + t1;
    assign sum_mag = sum[NW] ? NW'(-sum) : sum[NW-1:0];

    // reduced power base, inverted for a negative exponent
    assign p_sw = ex_reg[EXW-1] ? quo[W-1:0] : n_reg[W-1:0];
    assign q_sw = ex_reg[EXW-1] ? n_reg[W-1:0] : quo[W-1:0];
    assign lim  = (!ph_reg && neg_reg) ? NEG_MAX_W : POS_MAX_W;

    // normalize and range-check the final result
    always_comb begin
        n_f   = n_reg;
        d_f   = d_reg;
        neg_f = neg_reg;
        st_f  = st_reg;
        if (st_f == rau_pkg::ST_OK) begin
            if (n_f == '0) begin
                d_f   = NW'(1);
                neg_f = 1'b0;
            end
            if ((n_f > (neg_f ? NEG_MAX_N : POS_MAX_N)) || (d_f > POS_MAX_N)) begin
                st_f = rau_pkg::ST_OVF;
            end
        end
        if (st_f != rau_pkg::ST_OK) begin
            n_f   = '0;
            d_f   = NW'(1);
            neg_f = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bn_next    = bn_reg;
        bd_next    = bd_reg;
        ex_next    = ex_reg;
        k_next     = k_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        g_next     = g_reg;
        neg_next   = neg_reg;
        st_next    = st_reg;
        go_next    = 1'b0;
        bp_next    = bp_reg;
        bq_next    = bq_reg;
        acc_next   = acc_reg;
        ph_next    = ph_reg;
        half_next  = half_reg;
        i_next     = i_reg;
        mv_next    = mv_reg && !m_tready;
        rnum_next  = rnum_reg;
        rden_next  = rden_reg;
        rst_next   = rst_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    an_next    = s_tdata[W-1:0];
                    ad_next    = s_tdata[2*W-1:W];
                    bn_next    = s_tdata[3*W-1:2*W];
                    bd_next    = s_tdata[4*W-1:3*W];
                    ex_next    = s_tdata[4*W+EXW-1:4*W];
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                st_next  = rau_pkg::ST_OK;
                n_next   = '0;
                d_next   = NW'(1);
                neg_next = 1'b0;
                if (cmd_reg > rau_pkg::CMD_POW) begin
                    state_next = S_FIN;
                end else if ((ad_reg == '0)
                        || ((cmd_reg <= rau_pkg::CMD_DIV) && (bd_reg == '0))
                        || ((cmd_reg == rau_pkg::CMD_DIV) && (bn_reg == '0))
                        || ((cmd_reg == rau_pkg::CMD_POW) && ex_reg[EXW-1] && (an_reg == '0)))
                        begin
                    st_next    = rau_pkg::ST_DIV0;
                    state_next = S_FIN;
                end else if ((cmd_reg == rau_pkg::CMD_POW) && (ex_mag > EXW'(EXP_MAX))) begin
                    st_next    = rau_pkg::ST_OVF;
                    state_next = S_FIN;
                end else begin
                    k_next     = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                k_next = k_reg + 2'd1;
                case (k_reg)
                    2'd1: p0_next = prod;
                    2'd2: p1_next = prod;
                    2'd3: begin
                        n_next     = sum_mag;
                        d_next     = {1'b0, prod};
                        neg_next   = (cmd_reg == rau_pkg::CMD_ABS) ? 1'b0 : (sum[NW] ^ sden);
                        go_next    = 1'b1;
                        state_next = S_GCD;
                    end
                    default: ;
                endcase
            end
            S_GCD: begin
                if (gcd_sts.done) begin
                    g_next     = gcd_g;
                    go_next    = 1'b1;
                    state_next = S_DIVN;
                end
            end
            S_DIVN: begin
                if (div_sts.done) begin
                    n_next     = quo;
                    go_next    = 1'b1;
                    state_next = S_DIVD;
                end
            end
            S_DIVD: begin
                if (div_sts.done) begin
                    if (cmd_reg == rau_pkg::CMD_POW) begin
                        bp_next    = p_sw;
                        bq_next    = q_sw;
                        neg_next   = neg_reg && (p_sw != '0) && ex_mag[0];
                        acc_next   = W'(1);
                        ph_next    = 1'b0;
                        half_next  = 1'b0;
                        i_next     = '0;
                        state_next = S_POW;
                    end else begin
                        d_next     = quo;
                        state_next = S_FIN;
                    end
                end
            end
            S_POW: begin
                if (i_reg == ex_mag) begin
                    if (!ph_reg) begin
                        n_next    = NW'(acc_reg);
                        ph_next   = 1'b1;
                        acc_next  = W'(1);
                        i_next    = '0;
                        half_next = 1'b0;
                    end else begin
                        d_next     = NW'(acc_reg);
                        state_next = S_FIN;
                    end
                end else if (!half_reg) begin
                    half_next = 1'b1;
                end else begin
                    half_next = 1'b0;
                    if (prod > (2*W)'(lim)) begin
                        st_next    = rau_pkg::ST_OVF;
                        state_next = S_FIN;
                    end else begin
                        acc_next = prod[W-1:0];
                        i_next   = i_reg + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (!mv_reg || m_tready) begin
                    rnum_next  = neg_f ? (~n_f[W-1:0] + 1'b1) : n_f[W-1:0];
                    rden_next  = d_f[W-2:0];
                    rst_next   = st_f;
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
            mv_reg    <= mv_next;
        end
        cmd_reg  <= cmd_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        bn_reg   <= bn_next;
        bd_reg   <= bd_next;
        ex_reg   <= ex_next;
        k_reg    <= k_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        g_reg    <= g_next;
        neg_reg  <= neg_next;
        st_reg   <= st_next;
        bp_reg   <= bp_next;
        bq_reg   <= bq_next;
        acc_reg  <= acc_next;
        ph_reg   <= ph_next;
        half_reg <= half_next;
        i_reg    <= i_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
        rst_reg  <= rst_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = OUT_W'({rden_reg, rnum_reg});
    assign m_tuser  = rst_reg;

endmodule

### hdl/rau_mul.sv
module rau_mul #(
    parameter int WIDTH = 16
) (
    input  logic               aclk,
    input  logic [WIDTH-1:0]   x,
    input  logic [WIDTH-1:0]   y,
    output logic [2*WIDTH-1:0] prod
);

    logic [2*WIDTH-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= (2*WIDTH)'(x) * (2*WIDTH)'(y);
    end

    assign prod = prod_reg;

endmodule

### hdl/rau_gcd.sv
module rau_gcd #(
    parameter int WIDTH = 33
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WIDTH-1:0]  x,
    input  logic [WIDTH-1:0]  y,
    output rau_pkg::unit_sts_t sts,
    output logic [WIDTH-1:0]  g
);

    localparam int KW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] u_reg, u_next, v_reg, v_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [WIDTH:0]   diff, diff_vu;

    // binary gcd: one shift or subtract-and-shift per cycle
    always_comb begin
        u_next    = u_reg;
        v_next    = v_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        diff      = {1'b0, u_reg} - {1'b0, v_reg};
        diff_vu   = {1'b0, v_reg} - {1'b0, u_reg};
        if (start) begin
            u_next    = x;
            v_next    = y;
            k_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (u_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!u_reg[0] && !v_reg[0]) begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_next = u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_next = v_reg >> 1;
            end else if (!diff[WIDTH]) begin
                u_next = diff[WIDTH:1];
            end else begin
                v_next = diff_vu[WIDTH:1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        u_reg <= u_next;
        v_reg <= v_next;
        k_reg <= k_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign g        = v_reg << k_reg;

endmodule

### hdl/rau_div.sv
module rau_div #(
    parameter int WIDTH = 33
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WIDTH-1:0]  a,
    input  logic [WIDTH-1:0]  b,
    output rau_pkg::unit_sts_t sts,
    output logic [WIDTH-1:0]  q
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next, quo_reg, quo_next, div_reg, div_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [WIDTH:0]   sh;
    logic [WIDTH+1:0] diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = {rem_reg, quo_reg[WIDTH-1]};
        diff      = {1'b0, sh} - {2'b00, div_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = a;
            div_next  = b;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[WIDTH+1]) begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = sh[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign q        = quo_reg;

endmodule

### hdl/rau_checker.sv
`include "rational_arith_unit_defines.svh"

module rau_checker #(
    parameter int OPERAND_WIDTH = 16
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((2*OPERAND_WIDTH-1+7)/8)*8-1:0] m_tdata,
    input logic [rau_pkg::ST_W-1:0]               m_tuser
);

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0] res_num;
    logic [W-2:0] res_den;
    logic         err_shape, st_legal, st_err;

    assign res_num   = m_tdata[W-1:0];
    assign res_den   = m_tdata[2*W-2:W];
    assign err_shape = (res_num == '0) && (res_den == (W-1)'(1));
    assign st_err    = (m_tuser != rau_pkg::ST_OK);
    assign st_legal  = (m_tuser == rau_pkg::ST_OK) || (m_tuser == rau_pkg::ST_OVF)
                    || (m_tuser == rau_pkg::ST_DIV0);

    `RAU_ASSERT(chk_out_hold, (m_tvalid && !m_tready) |=> m_tvalid)
    `RAU_ASSERT_MSG(chk_busy, (s_tvalid && s_tready) |=> !s_tready, "input taken while busy")
    `RAU_ASSERT_MSG(chk_den, m_tvalid |-> (res_den != '0), "zero denominator")
    `RAU_ASSERT_MSG(chk_err, (m_tvalid && st_err) |-> err_shape, "error result not 0/1")
    `RAU_ASSERT_MSG(chk_code, m_tvalid |-> st_legal, "bad status code")

endmodule

bind rational_arith_unit rau_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_rau_checker (.*);
